// File: sv/lrbsf_pkg.sv
// ----------------------------------------------------------------------------
// lrbsf_pkg
// Shared types, marks and escape table for the log record byte-stuffing framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrbsf_pkg;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_PAYLOAD = 2'd1;
  localparam logic [1:0] REQ_END     = 2'd2;

  localparam logic [7:0] MARK_START = 8'hEB;
  localparam logic [7:0] MARK_ESC   = 8'hEC;
  localparam logic [7:0] MARK_END   = 8'hEE;
  localparam logic [7:0] MARK_TICK  = 8'hED;
  localparam logic [7:0] CTRL_XON   = 8'h11;
  localparam logic [7:0] CTRL_XOFF  = 8'h13;

  localparam int unsigned BURST_MAX = 3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [1:0]                last_idx;
  } burst_t;

  typedef struct packed {
    logic       go;
    logic [7:0] sum_nxt;
    burst_t     burst;
  } enc_t;

  typedef struct packed {
    logic       esc;
    logic [7:0] code;
  } esc_t;

  function automatic esc_t esc_lookup(input logic [7:0] v);
    esc_t r;
    r.esc  = 1'b1;
    r.code = 8'd0;
    unique case (v)
      MARK_START: r.code = 8'd0;
      MARK_ESC:   r.code = 8'd1;
      MARK_END:   r.code = 8'd2;
      MARK_TICK:  r.code = 8'd3;
      CTRL_XON:   r.code = 8'd4;
      CTRL_XOFF:  r.code = 8'd5;
      default:    r.esc  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/lrbsf_encode.sv
// ----------------------------------------------------------------------------
// lrbsf_encode
// Turns one request into a burst of up to three framed bytes and the next sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbsf_encode (
  input  wire lrbsf_pkg::in_t  req,
  input  wire logic [7:0]      sum,
  output lrbsf_pkg::enc_t      enc
);

  lrbsf_pkg::esc_t pay_esc;
  lrbsf_pkg::esc_t sum_esc;

  assign pay_esc = lrbsf_pkg::esc_lookup(req.byte_value);
  assign sum_esc = lrbsf_pkg::esc_lookup(sum);

  always_comb begin
    enc = '0;
    enc.sum_nxt = sum;
    unique case (req.req_type)
      lrbsf_pkg::REQ_START: begin
        enc.go             = 1'b1;
        enc.sum_nxt        = req.byte_value;
        enc.burst.bytes[0] = lrbsf_pkg::MARK_START;
        enc.burst.bytes[1] = req.byte_value;
        enc.burst.last_idx = 2'd1;
      end
      lrbsf_pkg::REQ_PAYLOAD: begin
        enc.go      = 1'b1;
        enc.sum_nxt = sum + req.byte_value;
        if (pay_esc.esc) begin
          enc.burst.bytes[0] = lrbsf_pkg::MARK_ESC;
          enc.burst.bytes[1] = pay_esc.code;
          enc.burst.last_idx = 2'd1;
        end else begin
          enc.burst.bytes[0] = req.byte_value;
          enc.burst.last_idx = 2'd0;
        end
      end
      lrbsf_pkg::REQ_END: begin
        enc.go             = 1'b1;
        enc.burst.bytes[0] = lrbsf_pkg::MARK_END;
        if (sum_esc.esc) begin
          enc.burst.bytes[1] = lrbsf_pkg::MARK_ESC;
          enc.burst.bytes[2] = sum_esc.code;
          enc.burst.last_idx = 2'd2;
        end else begin
          enc.burst.bytes[1] = sum;
          enc.burst.last_idx = 2'd1;
        end
      end
      default: begin
        enc.go = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/lrbsf_serializer.sv
// ----------------------------------------------------------------------------
// lrbsf_serializer
// Holds one burst and sends it out one byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbsf_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire lrbsf_pkg::burst_t burst,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lrbsf_pkg::out_t        out_data
);

  lrbsf_pkg::burst_t burst_r;
  logic [1:0]        idx_r;
  logic              valid_r;
  logic              fire;
  logic              fin;

  assign fire     = valid_r && out_ready;
  assign fin      = fire && (idx_r == burst_r.last_idx);
  assign can_load = !valid_r || fin;

  assign out_valid            = valid_r;
  assign out_data.out_byte    = burst_r.bytes[idx_r];
  assign out_data.last_of_run = (idx_r == burst_r.last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (fin) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst;
    end
  end

endmodule

`default_nettype wire

// File: sv/log_record_byte_stuffing_framer_core.sv
// ----------------------------------------------------------------------------
// log_record_byte_stuffing_framer_core
// Byte-stuffing framer for log records with an 8-bit sum checksum.
// First byte of an item is valid in the cycle after its transfer.
// Throughput: one output byte per cycle while out_ready is high, set by the
// single output byte port; a new item is taken as the previous one ends.
// Reset: synchronous active-low; clears the running sum and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_byte_stuffing_framer_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lrbsf_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lrbsf_pkg::out_t      out_data
);

  lrbsf_pkg::enc_t enc;
  logic [7:0]      sum_r;
  logic            can_load;
  logic            take;

  lrbsf_encode u_encode (
    .req (in_data),
    .sum (sum_r),
    .enc (enc)
  );

  assign in_ready = can_load;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= 8'd0;
    end else if (take) begin
      sum_r <= enc.sum_nxt;
    end
  end

  lrbsf_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && enc.go),
    .burst     (enc.burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: test/log_record_byte_stuffing_framer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// log_record_byte_stuffing_framer_core_tb
// Feeds directed and random log record items (start, payload, end, unused code)
// to the framer, predicts the stuffed byte stream with its own copy of the
// running sum and checks every output transfer in order, under several
// sender idle and receiver stall mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------

module log_record_byte_stuffing_framer_core_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [7:0] ESC_CODE_START = 8'd0;
  localparam logic [7:0] ESC_CODE_ESC   = 8'd1;
  localparam logic [7:0] ESC_CODE_END   = 8'd2;
  localparam logic [7:0] ESC_CODE_TICK  = 8'd3;
  localparam logic [7:0] ESC_CODE_XON   = 8'd4;
  localparam logic [7:0] ESC_CODE_XOFF  = 8'd5;

  localparam int unsigned PHASE_ITEMS  = 76;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           out_ready = 1'b0;
  lrbsf_pkg::in_t in_data   = '0;
  logic            in_ready;
  logic            out_valid;
  lrbsf_pkg::out_t out_data;

  lrbsf_pkg::in_t  stim_q[$];
  lrbsf_pkg::out_t framed_q[$];
  logic [7:0]  link_sum = 8'd0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_cnt  = 0;
  int unsigned quiet_cnt = 0;
  int unsigned fail_cnt  = 0;

  log_record_byte_stuffing_framer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic bit stuff_code(input logic [7:0] v, output logic [7:0] code);
    bit hit;
    hit  = 1'b1;
    code = ESC_CODE_START;
    case (v)
      lrbsf_pkg::MARK_START: code = ESC_CODE_START;
      lrbsf_pkg::MARK_ESC:   code = ESC_CODE_ESC;
      lrbsf_pkg::MARK_END:   code = ESC_CODE_END;
      lrbsf_pkg::MARK_TICK:  code = ESC_CODE_TICK;
      lrbsf_pkg::CTRL_XON:   code = ESC_CODE_XON;
      lrbsf_pkg::CTRL_XOFF:  code = ESC_CODE_XOFF;
      default:               hit  = 1'b0;
    endcase
    return hit;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    lrbsf_pkg::out_t o;
    o.out_byte    = b;
    o.last_of_run = last;
    framed_q.push_back(o);
  endtask

  task automatic push_stuffed(input logic [7:0] v);
    logic [7:0] code;
    if (stuff_code(v, code)) begin
      push_byte(lrbsf_pkg::MARK_ESC, 1'b0);
      push_byte(code, 1'b1);
    end else begin
      push_byte(v, 1'b1);
    end
  endtask

  task automatic frame_item(input lrbsf_pkg::in_t item);
    case (item.req_type)
      lrbsf_pkg::REQ_START: begin
        push_byte(lrbsf_pkg::MARK_START, 1'b0);
        push_byte(item.byte_value, 1'b1);
        link_sum = item.byte_value;
      end
      lrbsf_pkg::REQ_PAYLOAD: begin
        link_sum = link_sum + item.byte_value;
        push_stuffed(item.byte_value);
      end
      lrbsf_pkg::REQ_END: begin
        push_byte(lrbsf_pkg::MARK_END, 1'b0);
        push_stuffed(link_sum);
      end
      default: ;
    endcase
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic queue_item(input logic [1:0] req, input logic [7:0] val);
    lrbsf_pkg::in_t item;
    item.req_type   = req;
    item.byte_value = val;
    stim_q.push_back(item);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(5))
        0: v = lrbsf_pkg::MARK_START;
        1: v = lrbsf_pkg::MARK_ESC;
        2: v = lrbsf_pkg::MARK_END;
        3: v = lrbsf_pkg::MARK_TICK;
        4: v = lrbsf_pkg::CTRL_XON;
        default: v = lrbsf_pkg::CTRL_XOFF;
      endcase
    end
    return v;
  endfunction

  // Mostly whole records; some lose their start or end, some stray items.
  task automatic queue_random(input int unsigned count);
    int unsigned queued;
    int unsigned len;
    int unsigned r;
    queued = 0;
    while (queued < count) begin
      r = $urandom_range(99);
      if (r < 85) begin
        len = $urandom_range(6);
        if (r >= 5) begin
          queue_item(lrbsf_pkg::REQ_START, pick_byte());
          queued++;
        end
        repeat (len) queue_item(lrbsf_pkg::REQ_PAYLOAD, pick_byte());
        queued += len;
        if (r < 5 || r >= 10) begin
          queue_item(lrbsf_pkg::REQ_END, 8'($urandom_range(255)));
          queued++;
        end
      end else begin
        queue_item(2'($urandom_range(3)), pick_byte());
        if (stim_q[$].req_type != REQ_UNUSED) queued++;
      end
    end
  endtask

  task automatic wait_sent();
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : monitor
    lrbsf_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) frame_item(in_data);
      if (out_valid && out_ready) begin
        if (framed_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got %h/%b",
                   $time, out_data.out_byte, out_data.last_of_run);
          fail_cnt++;
        end else begin
          want = framed_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h, got %h",
                     $time, want.out_byte, out_data.out_byte);
            fail_cnt++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %b, got %b",
                     $time, want.last_of_run, out_data.last_of_run);
            fail_cnt++;
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cnt);
        $display("log_record_byte_stuffing_framer_core_tb NOT OK");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_item(lrbsf_pkg::REQ_END, 8'h00);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::CTRL_XOFF);
    queue_item(REQ_UNUSED, 8'hFF);
    queue_item(lrbsf_pkg::REQ_START, lrbsf_pkg::MARK_START);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::MARK_START);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::MARK_ESC);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::MARK_END);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::MARK_TICK);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::CTRL_XON);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::CTRL_XOFF);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, 8'h00);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, 8'hFF);
    queue_item(lrbsf_pkg::REQ_END, 8'hFF);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, 8'h7F);
    queue_item(lrbsf_pkg::REQ_END, 8'h00);
    queue_item(lrbsf_pkg::REQ_START, 8'hFF);
    queue_item(lrbsf_pkg::REQ_END, 8'h00);
    queue_item(lrbsf_pkg::REQ_START, lrbsf_pkg::CTRL_XON);
    queue_item(lrbsf_pkg::REQ_END, 8'h00);
    queue_item(lrbsf_pkg::REQ_START, 8'h00);
    queue_item(lrbsf_pkg::REQ_PAYLOAD, lrbsf_pkg::MARK_TICK);
    queue_item(lrbsf_pkg::REQ_END, 8'h00);
    queue_item(REQ_UNUSED, 8'h00);
    queue_item(lrbsf_pkg::REQ_START, 8'h5A);
    queue_item(lrbsf_pkg::REQ_END, 8'h00);
    wait_sent();

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    queue_random(PHASE_ITEMS);
    wait_sent();

    send_idle_pct = 51;
    queue_random(PHASE_ITEMS);
    wait_sent();

    send_idle_pct = 0;
    stall_pct     = 51;
    queue_random(PHASE_ITEMS);
    wait_sent();

    send_idle_pct = 32;
    stall_pct     = 32;
    queue_random(PHASE_ITEMS);
    wait_sent();

    while (framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (framed_q.size() != 0) begin
      $display("%0t: %0d expected transfers never arrived", $time, framed_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("log_record_byte_stuffing_framer_core_tb OK");
    end else begin
      $display("log_record_byte_stuffing_framer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
